/* rtl/evm_pkg.sv */
// Shared types and constants for the YXZ Euler view matrix block.
package evm_pkg;

	localparam int ZW = 32;
	localparam int MAX_STEPS = 30;
	localparam logic [63:0] GAIN_Q32 = 64'h0000_0000_9B74_EDA8;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// arctangent of 2^-i, 2^32 per turn
	localparam logic signed [ZW-1:0] ATAN_TURN32 [MAX_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
		32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
	};

endpackage

/* rtl/euler_yxz_view_matrix.sv */
// Top level: YXZ Euler-angle view matrix with translation, fixed point.
// Stages from accept to result: one CORDIC cell per step, quadrant fold, two
// product stages, matrix sum, translation products, translation sum.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Reset clears the valid bits only; no state is kept between items.
module euler_yxz_view_matrix
	import evm_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int TRIG_FRAC_BITS = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [31:0]           pos_x,
	input  logic signed [31:0]           pos_y,
	input  logic signed [31:0]           pos_z,
	input  logic signed [ANGLE_BITS-1:0] angle_pitch,
	input  logic signed [ANGLE_BITS-1:0] angle_yaw,
	input  logic signed [ANGLE_BITS-1:0] angle_roll,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [15:0]           u_x,
	output logic signed [15:0]           u_y,
	output logic signed [15:0]           u_z,
	output logic signed [15:0]           v_x,
	output logic signed [15:0]           v_y,
	output logic signed [15:0]           v_z,
	output logic signed [15:0]           w_x,
	output logic signed [15:0]           w_y,
	output logic signed [15:0]           w_z,
	output logic signed [31:0]           trans_u,
	output logic signed [31:0]           trans_v,
	output logic signed [31:0]           trans_w
);

	localparam int TF = TRIG_FRAC_BITS;
	localparam int N  = (TF + 1 < MAX_STEPS) ? TF + 1 : MAX_STEPS;
	localparam int XW = TF + 3;
	localparam int CW = TF + 2;
	localparam int PW = CW + 32;
	localparam int DW = PW + 3;
	localparam int D  = N + 1;
	localparam int L  = D + 5;
	localparam logic [63:0] X0_U = (GAIN_Q32 + (64'd1 << (31 - TF))) >> (32 - TF);
	localparam logic signed [XW-1:0] X0 = XW'(X0_U);
	localparam logic signed [CW:0]   ONE = (CW+1)'(1) <<< TF;
	localparam logic signed [2*CW-1:0] RND = (2*CW)'(1) <<< (TF - 1);
	localparam logic signed [DW-1:0] RND_D = DW'(1) <<< (TF - 1);
	localparam logic signed [DW-1:0] SMAX = DW'(33'sh0_7FFF_FFFF);
	localparam logic signed [DW-1:0] SMIN = -DW'(33'sh0_8000_0000);

	function automatic logic signed [CW-1:0] fmul(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = a * b + RND;
		return CW'(p >>> TF);
	endfunction

	function automatic logic signed [CW-1:0] clamp1(input logic signed [CW:0] v);
		logic signed [CW-1:0] r;
		if (v > ONE) r = CW'(ONE);
		else if (v < -ONE) r = CW'(-ONE);
		else r = CW'(v);
		return r;
	endfunction

	logic                 adv;
	logic [L-1:0]         vld_q;
	logic signed [31:0]   pos_q [0:D+2][3];
	logic signed [CW-1:0] c1, s1, c2, s2, c3, s3;
	logic signed [CW-1:0] p_s1 [10];
	logic signed [CW-1:0] s2_s1, s3_s1;
	logic signed [CW-1:0] p_s2 [10];
	logic signed [CW-1:0] t_s2 [4];
	logic signed [CW-1:0] m_s3 [9];
	logic signed [PW-1:0] pr_s4 [9];
	logic signed [CW-1:0] m_s4 [9];
	logic signed [31:0]   tr_s5 [3];
	logic signed [CW-1:0] m_s5 [9];
	logic signed [DW-1:0] dot [3];
	logic signed [DW-1:0] neg [3];

	assign adv       = !(vld_q[L-1] && out_stall);
	assign in_stall  = vld_q[L-1] && out_stall;
	assign out_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q[0][0] <= pos_x;
			pos_q[0][1] <= pos_y;
			pos_q[0][2] <= pos_z;
			for (int i = 1; i <= D + 2; i++) begin
				pos_q[i] <= pos_q[i-1];
			end
		end
	end

	evm_sincos #(.AB(ANGLE_BITS), .TF(TF), .N(N), .XW(XW), .CW(CW), .X0(X0)) u_pitch (
		.clk(clk), .en(adv), .angle(angle_pitch), .cos_q(c2), .sin_q(s2)
	);
	evm_sincos #(.AB(ANGLE_BITS), .TF(TF), .N(N), .XW(XW), .CW(CW), .X0(X0)) u_yaw (
		.clk(clk), .en(adv), .angle(angle_yaw), .cos_q(c1), .sin_q(s1)
	);
	evm_sincos #(.AB(ANGLE_BITS), .TF(TF), .N(N), .XW(XW), .CW(CW), .X0(X0)) u_roll (
		.clk(clk), .en(adv), .angle(angle_roll), .cos_q(c3), .sin_q(s3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= fmul(c1, c3);
			p_s1[1] <= fmul(s1, s2);
			p_s1[2] <= fmul(c2, s3);
			p_s1[3] <= fmul(c1, s2);
			p_s1[4] <= fmul(c3, s1);
			p_s1[5] <= fmul(c1, s3);
			p_s1[6] <= fmul(c2, c3);
			p_s1[7] <= fmul(s1, s3);
			p_s1[8] <= fmul(c2, s1);
			p_s1[9] <= fmul(c1, c2);
			s2_s1   <= s2;
			s3_s1   <= s3;

			for (int k = 0; k < 10; k++) begin
				if (k == 1) p_s2[k] <= -s2_s1;
				else p_s2[k] <= p_s1[k];
			end
			t_s2[0] <= fmul(p_s1[1], s3_s1);
			t_s2[1] <= fmul(p_s1[3], s3_s1);
			t_s2[2] <= fmul(p_s1[4], s2_s1);
			t_s2[3] <= fmul(p_s1[0], s2_s1);

			m_s3[0] <= clamp1((CW+1)'(p_s2[0]) + (CW+1)'(t_s2[0]));
			m_s3[1] <= p_s2[2];
			m_s3[2] <= clamp1((CW+1)'(t_s2[1]) - (CW+1)'(p_s2[4]));
			m_s3[3] <= clamp1((CW+1)'(t_s2[2]) - (CW+1)'(p_s2[5]));
			m_s3[4] <= p_s2[6];
			m_s3[5] <= clamp1((CW+1)'(t_s2[3]) + (CW+1)'(p_s2[7]));
			m_s3[6] <= p_s2[8];
			m_s3[7] <= clamp1((CW+1)'(p_s2[1]));
			m_s3[8] <= p_s2[9];

			for (int k = 0; k < 9; k++) begin
				pr_s4[k] <= PW'(m_s3[k]) * PW'(pos_q[D+2][k%3]);
			end
			m_s4 <= m_s3;

			for (int r = 0; r < 3; r++) begin
				if (neg[r] > SMAX) tr_s5[r] <= 32'(SMAX);
				else if (neg[r] < SMIN) tr_s5[r] <= 32'(SMIN);
				else tr_s5[r] <= 32'(neg[r]);
			end
			m_s5 <= m_s4;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			dot[r] = DW'(pr_s4[3*r]) + DW'(pr_s4[3*r+1]) + DW'(pr_s4[3*r+2]);
			neg[r] = -((dot[r] + RND_D) >>> TF);
		end
	end

	assign u_x     = 16'(m_s5[0]);
	assign u_y     = 16'(m_s5[1]);
	assign u_z     = 16'(m_s5[2]);
	assign v_x     = 16'(m_s5[3]);
	assign v_y     = 16'(m_s5[4]);
	assign v_z     = 16'(m_s5[5]);
	assign w_x     = 16'(m_s5[6]);
	assign w_y     = 16'(m_s5[7]);
	assign w_z     = 16'(m_s5[8]);
	assign trans_u = tr_s5[0];
	assign trans_v = tr_s5[1];
	assign trans_w = tr_s5[2];

endmodule

/* rtl/evm_cordic_cell.sv */
// One CORDIC rotation step, registered.
module evm_cordic_cell
	import evm_pkg::*;
#(
	parameter int IDX = 0,
	parameter int XW = 17
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  quad_t                quad_in,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output quad_t                quad_out
);

	localparam logic signed [ZW-1:0] AT = ATAN_TURN32[IDX];

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_in >= 0) begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				z_out <= z_in - AT;
			end else begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				z_out <= z_in + AT;
			end
			quad_out <= quad_in;
		end
	end

endmodule

/* rtl/evm_sincos.sv */
// Sine and cosine of a binary angle: chain of CORDIC cells and quadrant fold.
module evm_sincos
	import evm_pkg::*;
#(
	parameter int AB = 16,
	parameter int TF = 14,
	parameter int N = 15,
	parameter int XW = 17,
	parameter int CW = 16,
	parameter logic signed [XW-1:0] X0 = '0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic        [AB-1:0] angle,
	output logic signed [CW-1:0] cos_q,
	output logic signed [CW-1:0] sin_q
);

	localparam logic signed [XW-1:0] ONE = XW'(1) <<< TF;

	logic        [ZW-1:0]   phase;
	logic signed [XW-1:0]   x_c [0:N];
	logic signed [XW-1:0]   y_c [0:N];
	logic signed [ZW-1:0]   z_c [0:N];
	quad_t                  q_c [0:N];
	logic signed [XW-1:0]   c_raw;
	logic signed [XW-1:0]   s_raw;

	assign phase  = {angle, {(ZW-AB){1'b0}}};
	assign x_c[0] = X0;
	assign y_c[0] = '0;
	assign z_c[0] = {2'b00, phase[ZW-3:0]};
	assign q_c[0] = quad_t'(phase[ZW-1:ZW-2]);

	for (genvar i = 0; i < N; i++) begin : g_cell
		evm_cordic_cell #(.IDX(i), .XW(XW)) u_cell (
			.clk     (clk),
			.en      (en),
			.x_in    (x_c[i]),
			.y_in    (y_c[i]),
			.z_in    (z_c[i]),
			.quad_in (q_c[i]),
			.x_out   (x_c[i+1]),
			.y_out   (y_c[i+1]),
			.z_out   (z_c[i+1]),
			.quad_out(q_c[i+1])
		);
	end

	always_comb begin
		case (q_c[N])
			QUAD_I: begin
				c_raw = x_c[N];
				s_raw = y_c[N];
			end
			QUAD_II: begin
				c_raw = -y_c[N];
				s_raw = x_c[N];
			end
			QUAD_III: begin
				c_raw = -x_c[N];
				s_raw = -y_c[N];
			end
			default: begin
				c_raw = y_c[N];
				s_raw = -x_c[N];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (c_raw > ONE) cos_q <= CW'(ONE);
			else if (c_raw < -ONE) cos_q <= CW'(-ONE);
			else cos_q <= CW'(c_raw);
			if (s_raw > ONE) sin_q <= CW'(ONE);
			else if (s_raw < -ONE) sin_q <= CW'(-ONE);
			else sin_q <= CW'(s_raw);
		end
	end

endmodule
